>>> src/plyuv_pkg.sv
// Shared constants, types and helpers for the luma offset pixel unit.
// Fixed-point coefficients for the RGB/YUV round trip; no dependencies.
package plyuv_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int SUM_W          = COEF_FRAC_BITS + 12;
    localparam int STAGES         = 4;
    localparam int LUMA_CAP       = 235;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [7:0]              byte_t;
    typedef logic signed [8:0]       diff_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctl_t;

    // round(c * 2^COEF_FRAC_BITS), half up
    localparam sum_t K_YR = sum_t'(((longint'(299)    << COEF_FRAC_BITS) + 500)    / 1000);
    localparam sum_t K_YG = sum_t'(((longint'(587)    << COEF_FRAC_BITS) + 500)    / 1000);
    localparam sum_t K_YB = sum_t'(((longint'(114)    << COEF_FRAC_BITS) + 500)    / 1000);
    localparam sum_t K_UR = sum_t'(((longint'(14713)  << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t K_UG = sum_t'(((longint'(28886)  << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t K_UB = sum_t'(((longint'(436)    << COEF_FRAC_BITS) + 500)    / 1000);
    localparam sum_t K_VR = sum_t'(((longint'(615)    << COEF_FRAC_BITS) + 500)    / 1000);
    localparam sum_t K_VG = sum_t'(((longint'(51499)  << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t K_VB = sum_t'(((longint'(10001)  << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t K_RV = sum_t'(((longint'(113983) << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t K_GU = sum_t'(((longint'(39465)  << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t K_GV = sum_t'(((longint'(58060)  << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t K_BU = sum_t'(((longint'(203211) << COEF_FRAC_BITS) + 50000) / 100000);
    localparam sum_t OFS_128 = sum_t'(longint'(128) << COEF_FRAC_BITS);

    // clamp a scaled sum to a byte, dropping the fraction
    function automatic byte_t to_byte(input sum_t s);
        sum_t  sh;
        byte_t res;
        sh = s >>> COEF_FRAC_BITS;
        if (s < 0)
        begin
            res = 8'd0;
        end
        else if (sh > sum_t'(255))
        begin
            res = 8'd255;
        end
        else
        begin
            res = sh[7:0];
        end
        return res;
    endfunction

endpackage

>>> src/plyuv_datapath.sv
// Four-stage datapath: RGB to YUV sums, luma adjust, YUV to RGB sums, byte clamp.
// Uses plyuv_pkg; stage loads come from the pipeline control in the top level.
module plyuv_datapath
    import plyuv_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  logic [31:0] in_data,   // chan0, chan1, chan2, chan3
    input  logic      in_last,
    input  byte_t     luma_offset,
    output logic [31:0] out_data,  // out0, out1, out2, out3
    output logic      out_last
);

    // stage 1: forward sums
    sum_t  ysum_reg, usum_reg, vsum_reg;
    byte_t a1_reg;
    logic  l1_reg;
    // stage 2: adjusted luma and chroma differences
    byte_t luma_reg;
    diff_t du_reg, dv_reg;
    byte_t a2_reg;
    logic  l2_reg;
    // stage 3: inverse sums
    sum_t  rsum_reg, gsum_reg, bsum_reg;
    byte_t a3_reg;
    logic  l3_reg;
    // stage 4: output
    logic [31:0] out_reg;
    logic  l4_reg;

    sum_t  r_in, g_in, b_in;
    sum_t  ysum_next, usum_next, vsum_next;
    byte_t y_b, u_b, v_b;
    logic [8:0] lsum;
    byte_t luma_next;
    diff_t du_next, dv_next;
    sum_t  yf, du_x, dv_x;
    sum_t  rsum_next, gsum_next, bsum_next;

    always_comb
    begin
        r_in = sum_t'(in_data[7:0]);
        g_in = sum_t'(in_data[15:8]);
        b_in = sum_t'(in_data[23:16]);
        ysum_next = K_YR * r_in + K_YG * g_in + K_YB * b_in;
        usum_next = OFS_128 - K_UR * r_in - K_UG * g_in + K_UB * b_in;
        vsum_next = OFS_128 + K_VR * r_in - K_VG * g_in - K_VB * b_in;

        y_b  = to_byte(ysum_reg);
        u_b  = to_byte(usum_reg);
        v_b  = to_byte(vsum_reg);
        lsum = {1'b0, y_b} + {1'b0, luma_offset};
        luma_next = (lsum > 9'(LUMA_CAP)) ? 8'(LUMA_CAP) : lsum[7:0];
        du_next = $signed({1'b0, u_b} - 9'd128);
        dv_next = $signed({1'b0, v_b} - 9'd128);

        yf   = sum_t'(luma_reg) <<< COEF_FRAC_BITS;
        du_x = sum_t'(du_reg);
        dv_x = sum_t'(dv_reg);
        rsum_next = yf + K_RV * dv_x;
        gsum_next = yf - K_GU * du_x - K_GV * dv_x;
        bsum_next = yf + K_BU * du_x;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            ysum_reg <= ysum_next;
            usum_reg <= usum_next;
            vsum_reg <= vsum_next;
            a1_reg   <= in_data[31:24];
            l1_reg   <= in_last;
        end
        if (ctl.load[1])
        begin
            luma_reg <= luma_next;
            du_reg   <= du_next;
            dv_reg   <= dv_next;
            a2_reg   <= a1_reg;
            l2_reg   <= l1_reg;
        end
        if (ctl.load[2])
        begin
            rsum_reg <= rsum_next;
            gsum_reg <= gsum_next;
            bsum_reg <= bsum_next;
            a3_reg   <= a2_reg;
            l3_reg   <= l2_reg;
        end
        if (ctl.load[3])
        begin
            out_reg <= {a3_reg, to_byte(bsum_reg), to_byte(gsum_reg), to_byte(rsum_reg)};
            l4_reg  <= l3_reg;
        end
    end

    assign out_data = out_reg;
    assign out_last = l4_reg;

endmodule

>>> src/pixel_luma_offset_via_yuv_unit.sv
// Top level: stream pixel unit that shifts luma through a YUV round trip.
// An accepted item moves through four register stages to output valid (the first loads at
// the accepting edge); throughput 1 item per cycle when the output is not stalled.
// Four register stages each hold one item; a stalled output backs up stage by stage.
// Reset (rst_n low, async) empties the pipeline and sets luma_offset to 0.
// Uses plyuv_pkg and plyuv_datapath.
module pixel_luma_offset_via_yuv_unit
    import plyuv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // chan0, chan1, chan2, chan3
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out0, out1, out2, out3
    output logic        m_tlast,   // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // luma_offset
);

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] rdy;
    byte_t     luma_offset_reg;
    pipe_ctl_t ctl;

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        ctl.load = rdy;
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            luma_offset_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_valid && cfg_ready)
            begin
                luma_offset_reg <= cfg_data;
            end
        end
    end

    plyuv_datapath u_dp
    (
        .clk         (clk),
        .ctl         (ctl),
        .in_data     (s_tdata),
        .in_last     (s_tlast),
        .luma_offset (luma_offset_reg),
        .out_data    (m_tdata),
        .out_last    (m_tlast)
    );

    assign s_tready  = rdy[0];
    assign m_tvalid  = vld_reg[STAGES-1];
    assign cfg_ready = 1'b1;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> s_tready)
        else $error("empty first stage refuses input");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STAGES-1] && !m_tready && vld_reg[STAGES-2] |=>
            vld_reg[STAGES-1] && vld_reg[STAGES-2])
        else $error("stalled item dropped inside pipeline");

endmodule
